/* sv/mlsta_pkg.sv */
`timescale 1ns / 1ps

package mlsta_pkg;

  localparam int unsigned MAX_NODES_DEF  = 1024;
  localparam int unsigned MAX_DEGREE_DEF = 16;

  localparam int unsigned NODE_W  = 10;
  localparam int unsigned COUNT_W = 11;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_EDGE    = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] edge_index;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic [NODE_W-1:0]  tree_edge_count;
    logic [COUNT_W-1:0] leaf_count;
    logic               overflow;
    logic [NODE_W-1:0]  parent;
    logic [NODE_W-1:0]  child;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage

/* sv/mlsta_ram.sv */
`timescale 1ns / 1ps

module mlsta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/mlsta_core.sv */
`timescale 1ns / 1ps

module mlsta_core #(
  parameter int unsigned MAX_NODES  = mlsta_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_DEGREE = mlsta_pkg::MAX_DEGREE_DEF,
  parameter int unsigned CW         = $clog2(MAX_NODES) + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  mlsta_pkg::in_t       cmd_i,
  input  logic [CW-1:0]        n_i,
  output mlsta_pkg::core_stat_t stat_o,
  output mlsta_pkg::out_t      res_o
);

  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned DW  = $clog2(MAX_DEGREE + 1);
  localparam int unsigned AAW = $clog2(MAX_NODES * MAX_DEGREE);
  localparam int unsigned SAW = $clog2(4 * MAX_NODES);

  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_DONE = 2'd1;
  localparam logic [1:0] MARK_SEEN = 2'd2;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LD_RD, S_LD_WR, S_RB, S_RB_OUT,
    S_ROOT, S_ROOT_CHK, S_FIND, S_POP_WAIT, S_T_MARK, S_T_LEN, S_T_ADJ0, S_T_UMARK,
    S_TF_LEN, S_TF_POP, S_TF_X, S_TF_XM, S_TF_APP0, S_TF_APP1, S_FAIL,
    S_EX, S_EX_LEN, S_EX_LOOP, S_EX_U, S_EX_UM, S_EX_END, S_LEAF, S_SUM
  } state_e;

  function automatic logic [AAW-1:0] adj_addr(logic [NW-1:0] node, logic [DW-1:0] slot);
    return AAW'(node) * AAW'(MAX_DEGREE) + AAW'(slot);
  endfunction

  function automatic logic [SAW-1:0] stk_addr(logic [1:0] tier, logic [NW-1:0] idx);
    return SAW'(tier) * SAW'(MAX_NODES) + SAW'(idx);
  endfunction

  state_e         state_q, state_d;
  mlsta_pkg::in_t cmd_q, cmd_d;
  logic [CW-1:0]  n_q, n_d;
  logic [1:0]     tier_q, tier_d;
  logic [CW-1:0]  r_q, r_d;
  logic [CW-1:0]  i_q, i_d;
  logic [NW-1:0]  v_q, v_d;
  logic [NW-1:0]  u_q, u_d;
  logic [NW-1:0]  x_q, x_d;
  logic [NW-1:0]  f0_q, f0_d;
  logic [NW-1:0]  f1_q, f1_d;
  logic [DW-1:0]  len_q, len_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [DW-1:0]  ix_q, ix_d;
  logic [DW-1:0]  e_q, e_d;
  logic [1:0]     dv_q, dv_d;
  logic [CW-1:0]  ptr_q [1:3];
  logic [CW-1:0]  ptr_d [1:3];
  logic [CW-1:0]  et_q, et_d;
  logic           ovf_q, ovf_d;
  logic [CW-1:0]  leaves_q, leaves_d;
  logic           pend_q, pend_d;
  logic           side_q, side_d;

  logic            adj_we;
  logic [AAW-1:0]  adj_waddr, adj_raddr;
  logic [NW-1:0]   adj_wdata, adj_rdata;
  logic            len_we;
  logic [NW-1:0]   len_waddr, len_raddr;
  logic [DW-1:0]   len_wdata, len_rdata;
  logic            mark_we;
  logic [NW-1:0]   mark_waddr, mark_raddr;
  logic [1:0]      mark_wdata, mark_rdata;
  logic            deg_we;
  logic [NW-1:0]   deg_waddr, deg_raddr;
  logic [1:0]      deg_wdata, deg_rdata;
  logic            stk_we;
  logic [SAW-1:0]  stk_waddr, stk_raddr;
  logic [NW-1:0]   stk_wdata, stk_rdata;
  logic            tree_we;
  logic [NW-1:0]   tree_waddr, tree_raddr;
  logic [2*NW-1:0] tree_wdata, tree_rdata;

  logic [NW-1:0]   src, dst;
  logic [CW-1:0]   ptr_m1;
  logic [1:0]      tier_lo;
  logic            rb_hit;

  mlsta_ram #(.WIDTH(NW), .DEPTH(MAX_NODES * MAX_DEGREE)) u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .raddr_i(adj_raddr), .rdata_o(adj_rdata)
  );
  mlsta_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(len_waddr), .wdata_i(len_wdata),
    .raddr_i(len_raddr), .rdata_o(len_rdata)
  );
  mlsta_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_mark (
    .clk_i, .we_i(mark_we), .waddr_i(mark_waddr), .wdata_i(mark_wdata),
    .raddr_i(mark_raddr), .rdata_o(mark_rdata)
  );
  mlsta_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_deg (
    .clk_i, .we_i(deg_we), .waddr_i(deg_waddr), .wdata_i(deg_wdata),
    .raddr_i(deg_raddr), .rdata_o(deg_rdata)
  );
  mlsta_ram #(.WIDTH(NW), .DEPTH(4 * MAX_NODES)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );
  mlsta_ram #(.WIDTH(2 * NW), .DEPTH(MAX_NODES)) u_tree (
    .clk_i, .we_i(tree_we), .waddr_i(tree_waddr), .wdata_i(tree_wdata),
    .raddr_i(tree_raddr), .rdata_o(tree_rdata)
  );

  assign src     = side_q ? NW'(cmd_q.node_b) : NW'(cmd_q.node_a);
  assign dst     = side_q ? NW'(cmd_q.node_a) : NW'(cmd_q.node_b);
  assign ptr_m1  = ptr_q[tier_q] - CW'(1);
  assign tier_lo = tier_q - 2'd1;
  assign rb_hit  = 32'(cmd_q.edge_index) < 32'(et_q);

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    n_d      = n_q;
    tier_d   = tier_q;
    r_d      = r_q;
    i_d      = i_q;
    v_d      = v_q;
    u_d      = u_q;
    x_d      = x_q;
    f0_d     = f0_q;
    f1_d     = f1_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    ix_d     = ix_q;
    e_d      = e_q;
    dv_d     = dv_q;
    ptr_d    = ptr_q;
    et_d     = et_q;
    ovf_d    = ovf_q;
    leaves_d = leaves_q;
    pend_d   = pend_q;
    side_d   = side_q;

    adj_we     = 1'b0;
    adj_waddr  = adj_addr(u_q, len_q);
    adj_wdata  = f0_q;
    adj_raddr  = adj_addr(v_q, ix_q);
    len_we     = 1'b0;
    len_waddr  = u_q;
    len_wdata  = len_q + DW'(cnt_q);
    len_raddr  = v_q;
    mark_we    = 1'b0;
    mark_waddr = x_q;
    mark_wdata = MARK_SEEN;
    mark_raddr = v_q;
    deg_we     = 1'b0;
    deg_waddr  = x_q;
    deg_wdata  = 2'd1;
    deg_raddr  = v_q;
    stk_we     = 1'b0;
    stk_waddr  = stk_addr(2'd3, ptr_q[3][NW-1:0]);
    stk_wdata  = x_q;
    stk_raddr  = stk_addr(tier_q, ptr_m1[NW-1:0]);
    tree_we    = 1'b0;
    tree_waddr = et_q[NW-1:0];
    tree_wdata = {v_q, x_q};
    tree_raddr = NW'(cmd_q.edge_index);

    res_o      = '0;
    stat_o.busy = (state_q != S_IDLE);
    stat_o.done = 1'b0;

    unique case (state_q)
      S_CLR: begin
        len_we     = 1'b1;
        len_waddr  = i_q[NW-1:0];
        len_wdata  = '0;
        mark_we    = 1'b1;
        mark_waddr = i_q[NW-1:0];
        mark_wdata = MARK_FREE;
        deg_we     = 1'b1;
        deg_waddr  = i_q[NW-1:0];
        deg_wdata  = 2'd0;
        i_d        = i_q + CW'(1);
        if (32'(i_q) == MAX_NODES - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_d = cmd_i;
          unique case (cmd_i.op)
            mlsta_pkg::OP_LOAD: begin
              side_d = 1'b0;
              if (32'(cmd_i.node_a) < MAX_NODES && 32'(cmd_i.node_b) < MAX_NODES) begin
                state_d = S_LD_RD;
              end
            end
            mlsta_pkg::OP_RUN: begin
              n_d     = n_i;
              r_d     = '0;
              state_d = S_ROOT;
            end
            mlsta_pkg::OP_READ: begin
              state_d = S_RB;
            end
            mlsta_pkg::OP_CLEAR: begin
              i_d      = '0;
              et_d     = '0;
              ovf_d    = 1'b0;
              ptr_d[1] = '0;
              ptr_d[2] = '0;
              ptr_d[3] = '0;
              state_d  = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_LD_RD: begin
        len_raddr = src;
        state_d   = S_LD_WR;
      end
      S_LD_WR: begin
        if (32'(len_rdata) >= MAX_DEGREE) begin
          ovf_d = 1'b1;
        end else begin
          adj_we    = 1'b1;
          adj_waddr = adj_addr(src, len_rdata);
          adj_wdata = dst;
          len_we    = 1'b1;
          len_waddr = src;
          len_wdata = len_rdata + DW'(1);
        end
        side_d  = 1'b1;
        state_d = side_q ? S_IDLE : S_LD_RD;
      end
      S_RB: begin
        state_d = S_RB_OUT;
      end
      S_RB_OUT: begin
        stat_o.done           = 1'b1;
        res_o.kind            = mlsta_pkg::KIND_EDGE;
        res_o.tree_edge_count = 10'(et_q);
        res_o.overflow        = ovf_q;
        if (rb_hit) begin
          res_o.parent = 10'(tree_rdata[2*NW-1:NW]);
          res_o.child  = 10'(tree_rdata[NW-1:0]);
        end
        state_d = S_IDLE;
      end
      S_ROOT: begin
        if (r_q == n_q) begin
          i_d      = '0;
          pend_d   = 1'b0;
          leaves_d = '0;
          state_d  = S_LEAF;
        end else begin
          mark_raddr = r_q[NW-1:0];
          state_d    = S_ROOT_CHK;
        end
      end
      S_ROOT_CHK: begin
        if (mark_rdata != MARK_FREE) begin
          r_d     = r_q + CW'(1);
          state_d = S_ROOT;
        end else begin
          ptr_d[1]   = '0;
          ptr_d[2]   = '0;
          ptr_d[3]   = CW'(1);
          stk_we     = 1'b1;
          stk_waddr  = stk_addr(2'd3, '0);
          stk_wdata  = r_q[NW-1:0];
          mark_we    = 1'b1;
          mark_waddr = r_q[NW-1:0];
          mark_wdata = MARK_SEEN;
          tier_d     = 2'd3;
          state_d    = S_FIND;
        end
      end
      S_FIND: begin
        if (ptr_q[tier_q] == '0) begin
          if (tier_q == 2'd1) begin
            r_d     = r_q + CW'(1);
            state_d = S_ROOT;
          end else begin
            tier_d = tier_lo;
          end
        end else begin
          ptr_d[tier_q] = ptr_m1;
          state_d       = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        v_d        = stk_rdata;
        mark_raddr = stk_rdata;
        state_d    = S_T_MARK;
      end
      S_T_MARK: begin
        len_raddr = v_q;
        if (mark_rdata == MARK_DONE) begin
          state_d = S_FAIL;
        end else if (tier_q == 2'd3) begin
          u_d     = v_q;
          state_d = S_TF_LEN;
        end else begin
          state_d = S_T_LEN;
        end
      end
      S_T_LEN: begin
        adj_raddr = adj_addr(v_q, '0);
        if (len_rdata == '0) begin
          state_d = S_FAIL;
        end else if (tier_q == 2'd1) begin
          state_d = S_EX;
        end else begin
          state_d = S_T_ADJ0;
        end
      end
      S_T_ADJ0: begin
        u_d        = adj_rdata;
        mark_raddr = adj_rdata;
        state_d    = S_T_UMARK;
      end
      S_T_UMARK: begin
        len_raddr = u_q;
        state_d   = (mark_rdata == MARK_DONE) ? S_FAIL : S_TF_LEN;
      end
      S_TF_LEN: begin
        len_d   = len_rdata;
        cnt_d   = 2'd0;
        state_d = S_TF_POP;
      end
      S_TF_POP: begin
        if (len_q == '0 || cnt_q == 2'd2) begin
          state_d = S_TF_APP0;
        end else begin
          adj_raddr = adj_addr(u_q, len_q - DW'(1));
          len_d     = len_q - DW'(1);
          state_d   = S_TF_X;
        end
      end
      S_TF_X: begin
        x_d        = adj_rdata;
        mark_raddr = adj_rdata;
        state_d    = S_TF_XM;
      end
      S_TF_XM: begin
        if (mark_rdata == MARK_FREE) begin
          if (cnt_q == 2'd0) begin
            f0_d = x_q;
          end else begin
            f1_d = x_q;
          end
          cnt_d = cnt_q + 2'd1;
        end
        state_d = S_TF_POP;
      end
      S_TF_APP0: begin
        adj_we  = (cnt_q != 2'd0);
        state_d = S_TF_APP1;
      end
      S_TF_APP1: begin
        adj_we    = (cnt_q == 2'd2);
        adj_waddr = adj_addr(u_q, len_q + DW'(1));
        adj_wdata = f1_q;
        len_we    = 1'b1;
        state_d   = (cnt_q == 2'd2) ? S_EX : S_FAIL;
      end
      S_FAIL: begin
        if (tier_q != 2'd1 && 32'(ptr_q[tier_lo]) < MAX_NODES) begin
          stk_we          = 1'b1;
          stk_waddr       = stk_addr(tier_lo, ptr_q[tier_lo][NW-1:0]);
          stk_wdata       = v_q;
          ptr_d[tier_lo]  = ptr_q[tier_lo] + CW'(1);
        end
        state_d = S_FIND;
      end
      S_EX: begin
        state_d = S_EX_LEN;
      end
      S_EX_LEN: begin
        e_d     = len_rdata;
        dv_d    = deg_rdata;
        ix_d    = '0;
        state_d = S_EX_LOOP;
      end
      S_EX_LOOP: begin
        if (ix_q == e_q) begin
          state_d = S_EX_END;
        end else begin
          ix_d    = ix_q + DW'(1);
          state_d = S_EX_U;
        end
      end
      S_EX_U: begin
        x_d        = adj_rdata;
        mark_raddr = adj_rdata;
        state_d    = S_EX_UM;
      end
      S_EX_UM: begin
        if (mark_rdata == MARK_FREE) begin
          if (32'(ptr_q[3]) < MAX_NODES) begin
            stk_we   = 1'b1;
            ptr_d[3] = ptr_q[3] + CW'(1);
          end
          if (32'(et_q) < MAX_NODES) begin
            tree_we = 1'b1;
            et_d    = et_q + CW'(1);
          end
          deg_we  = 1'b1;
          mark_we = 1'b1;
          dv_d    = (dv_q == 2'd2) ? 2'd2 : dv_q + 2'd1;
        end
        state_d = S_EX_LOOP;
      end
      S_EX_END: begin
        mark_we    = 1'b1;
        mark_waddr = v_q;
        mark_wdata = MARK_DONE;
        deg_we     = 1'b1;
        deg_waddr  = v_q;
        deg_wdata  = dv_q;
        tier_d     = 2'd3;
        state_d    = S_FIND;
      end
      S_LEAF: begin
        deg_raddr = i_q[NW-1:0];
        pend_d    = (i_q < n_q);
        if (i_q < n_q) begin
          i_d = i_q + CW'(1);
        end
        if (pend_q && deg_rdata == 2'd1) begin
          leaves_d = leaves_q + CW'(1);
        end
        if (i_q == n_q && !pend_q) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        stat_o.done           = 1'b1;
        res_o.kind            = mlsta_pkg::KIND_SUMMARY;
        res_o.tree_edge_count = 10'(et_q);
        res_o.leaf_count      = 11'(leaves_q);
        res_o.overflow        = ovf_q;
        state_d               = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      cmd_q    <= '0;
      n_q      <= '0;
      tier_q   <= 2'd3;
      r_q      <= '0;
      i_q      <= '0;
      v_q      <= '0;
      u_q      <= '0;
      x_q      <= '0;
      f0_q     <= '0;
      f1_q     <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
      ix_q     <= '0;
      e_q      <= '0;
      dv_q     <= '0;
      ptr_q    <= '{default: '0};
      et_q     <= '0;
      ovf_q    <= 1'b0;
      leaves_q <= '0;
      pend_q   <= 1'b0;
      side_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      n_q      <= n_d;
      tier_q   <= tier_d;
      r_q      <= r_d;
      i_q      <= i_d;
      v_q      <= v_d;
      u_q      <= u_d;
      x_q      <= x_d;
      f0_q     <= f0_d;
      f1_q     <= f1_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      ix_q     <= ix_d;
      e_q      <= e_d;
      dv_q     <= dv_d;
      ptr_q    <= ptr_d;
      et_q     <= et_d;
      ovf_q    <= ovf_d;
      leaves_q <= leaves_d;
      pend_q   <= pend_d;
      side_q   <= side_d;
    end
  end

endmodule

/* sv/max_leaf_spanning_tree_approx_unit.sv */
// load: appends the edge at both end nodes, no result; readback: reads the tree edge memory
// clear: resets all MAX_NODES node entries; run: visits each root candidate, pops and scans
// adjacency entries, then sweeps the nodes for the leaf count; one item is handled at a time
// all data passes through the shared read/write ports of the graph memories
// after reset a clearing sweep over all MAX_NODES entries runs before the first item is taken
`timescale 1ns / 1ps

module max_leaf_spanning_tree_approx_unit #(
  parameter int unsigned MAX_NODES  = mlsta_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_DEGREE = mlsta_pkg::MAX_DEGREE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mlsta_pkg::in_t                in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mlsta_pkg::out_t               out_item_o,
  input  logic                          cfg_we_i,
  input  logic [mlsta_pkg::COUNT_W-1:0] cfg_wdata_i
);

  localparam int unsigned CW = $clog2(MAX_NODES) + 1;

  logic [mlsta_pkg::COUNT_W-1:0] node_count_q;
  logic                          out_valid_q;
  mlsta_pkg::out_t               out_q;
  mlsta_pkg::core_stat_t         stat;
  mlsta_pkg::out_t               res;
  logic                          accept;
  logic [CW-1:0]                 n_use;

  assign in_stall_o = stat.busy || out_valid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign n_use      = (32'(node_count_q) < MAX_NODES) ? CW'(node_count_q) : CW'(MAX_NODES);

  mlsta_core #(.MAX_NODES(MAX_NODES), .MAX_DEGREE(MAX_DEGREE)) u_core (
    .clk_i,
    .rst_ni,
    .start_i(accept),
    .cmd_i  (in_item_i),
    .n_i    (n_use),
    .stat_o (stat),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= mlsta_pkg::NODE_COUNT_RESET;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (stat.done) begin
        out_valid_q <= 1'b1;
        out_q       <= res;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* verif/max_leaf_spanning_tree_approx_unit_test.sv */
`timescale 1ns / 1ps

module max_leaf_spanning_tree_approx_unit_test;

  localparam int NODES = 1024;
  localparam int DEGREE = 16;
  localparam int LIMIT = 4000000;
  localparam int SETTLE = 1200;
  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_DONE = 2'd1;
  localparam logic [1:0] MARK_SEEN = 2'd2;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  mlsta_pkg::in_t in_item_i;
  logic out_valid_o;
  logic out_stall_i;
  mlsta_pkg::out_t out_item_o;
  logic cfg_we_i;
  logic [mlsta_pkg::COUNT_W-1:0] cfg_wdata_i;

  max_leaf_spanning_tree_approx_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o(out_item_o),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // graph model state
  logic [9:0] adj [NODES][DEGREE];
  int adj_len [NODES];
  logic [1:0] mark [NODES];
  logic [9:0] tier_stk [4][NODES];
  int tier_sp [4];
  logic [9:0] edge_par [NODES];
  logic [9:0] edge_chi [NODES];
  int edge_cnt;
  int tree_deg [NODES];
  bit adj_ovf;
  int node_lim;

  mlsta_pkg::out_t results_due [$];
  int errors;
  int cycles;
  int items_sent;
  int idle_pct;
  int stall_pct;
  int hold_left;
  bit hold_req;

  typedef struct {
    mlsta_pkg::in_t item;
    bit typed;
    mlsta_pkg::out_t want;
  } row_t;
  row_t rows [$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void graph_clear();
    for (int i = 0; i < NODES; i++) begin
      adj_len[i] = 0;
      mark[i] = MARK_FREE;
      tree_deg[i] = 0;
    end
    for (int t = 0; t < 4; t++) tier_sp[t] = 0;
    edge_cnt = 0;
    adj_ovf = 1'b0;
  endfunction

  function automatic void adj_append(int a, int b);
    if (adj_len[a] >= DEGREE) begin
      adj_ovf = 1'b1;
    end else begin
      adj[a][adj_len[a]] = b[9:0];
      adj_len[a]++;
    end
  endfunction

  function automatic void tier_push(int t, int v);
    if (tier_sp[t] < NODES) begin
      tier_stk[t][tier_sp[t]] = v[9:0];
      tier_sp[t]++;
    end
  endfunction

  function automatic bit has_two_free(int u);
    int found [2];
    int cnt;
    int x;
    cnt = 0;
    if (mark[u] == MARK_DONE) return 1'b0;
    while (adj_len[u] > 0 && cnt < 2) begin
      x = adj[u][adj_len[u] - 1];
      adj_len[u]--;
      if (mark[x] == MARK_FREE) begin
        found[cnt] = x;
        cnt++;
      end
    end
    for (int i = 0; i < cnt; i++) adj_append(u, found[i]);
    return cnt >= 2;
  endfunction

  function automatic bit tier_ok(int t, int v);
    if (mark[v] == MARK_DONE) return 1'b0;
    if (t == 3) return has_two_free(v);
    if (adj_len[v] == 0) return 1'b0;
    if (t == 2) return has_two_free(adj[v][0]);
    return 1'b1;
  endfunction

  function automatic int pick_from_tier(int t);
    int v;
    while (tier_sp[t] > 0) begin
      tier_sp[t]--;
      v = tier_stk[t][tier_sp[t]];
      if (tier_ok(t, v)) return v;
      tier_push(t - 1, v);
    end
    return -1;
  endfunction

  function automatic void expand_node(int v);
    int u;
    for (int i = 0; i < adj_len[v]; i++) begin
      u = adj[v][i];
      if (mark[u] == MARK_FREE) begin
        tier_push(3, u);
        if (edge_cnt < NODES) begin
          edge_par[edge_cnt] = v[9:0];
          edge_chi[edge_cnt] = u[9:0];
          edge_cnt++;
        end
        tree_deg[v]++;
        tree_deg[u]++;
        mark[u] = MARK_SEEN;
      end
    end
    mark[v] = MARK_DONE;
  endfunction

  function automatic void grow_forest(int n);
    int v;
    for (int r = 0; r < n; r++) begin
      if (mark[r] == MARK_FREE) begin
        for (int t = 0; t < 4; t++) tier_sp[t] = 0;
        tier_push(3, r);
        mark[r] = MARK_SEEN;
        forever begin
          v = pick_from_tier(3);
          if (v < 0) v = pick_from_tier(2);
          if (v < 0) v = pick_from_tier(1);
          if (v < 0) break;
          expand_node(v);
        end
      end
    end
  endfunction

  // returns 1 when the item yields a result
  function automatic bit graph_step(mlsta_pkg::in_t x, output mlsta_pkg::out_t res);
    int n;
    int leaves;
    n = node_lim < NODES ? node_lim : NODES;
    res = '0;
    case (x.op)
      mlsta_pkg::OP_LOAD: begin
        adj_append(x.node_a, x.node_b);
        adj_append(x.node_b, x.node_a);
        return 1'b0;
      end
      mlsta_pkg::OP_CLEAR: begin
        graph_clear();
        return 1'b0;
      end
      mlsta_pkg::OP_RUN: begin
        grow_forest(n);
        leaves = 0;
        for (int i = 0; i < n; i++) if (tree_deg[i] == 1) leaves++;
        res.kind = mlsta_pkg::KIND_SUMMARY;
        res.tree_edge_count = edge_cnt[9:0];
        res.leaf_count = leaves[10:0];
        res.overflow = adj_ovf;
        return 1'b1;
      end
      default: begin
        res.kind = mlsta_pkg::KIND_EDGE;
        res.tree_edge_count = edge_cnt[9:0];
        res.overflow = adj_ovf;
        if (x.edge_index < edge_cnt) begin
          res.parent = edge_par[x.edge_index];
          res.child = edge_chi[x.edge_index];
        end
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  task automatic send_item(mlsta_pkg::in_t x, bit typed = 1'b0,
                           mlsta_pkg::out_t want = '0);
    bit st;
    mlsta_pkg::out_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= x;
    do begin
      @(negedge clk_i);
      st = in_stall_o;
      @(posedge clk_i);
    end while (st);
    items_sent++;
    if (graph_step(x, res)) results_due.insert(results_due.size(), typed ? want : res);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_node_count(int v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[10:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    node_lim = v;
  endtask

  function automatic mlsta_pkg::in_t mk(mlsta_pkg::op_e op, int a, int b, int idx);
    mlsta_pkg::in_t x;
    x.op = op;
    x.node_a = a[9:0];
    x.node_b = b[9:0];
    x.edge_index = idx[9:0];
    return x;
  endfunction

  task automatic add_row(mlsta_pkg::in_t x, bit typed = 1'b0, mlsta_pkg::out_t want = '0);
    row_t r;
    r.item = x;
    r.typed = typed;
    r.want = want;
    rows.insert(rows.size(), r);
  endtask

  task automatic noise_item();
    mlsta_pkg::in_t x;
    x = mlsta_pkg::in_t'($urandom);
    x.op = mlsta_pkg::op_e'($urandom_range(3));
    send_item(x);
  endtask

  // clear, load a sorted duplicate-free graph with occasional noise items, run, read back
  task automatic graph_sequence();
    int span;
    int dens;
    int base;
    int hub;
    int reads;
    span = $urandom_range(2, 22);
    dens = $urandom_range(10, 90);
    base = ($urandom_range(3) == 0) ? $urandom_range(0, NODES - 1 - span) : 0;
    hub = ($urandom_range(3) == 0) ? $urandom_range(0, span - 1) : -1;
    send_item(mk(mlsta_pkg::OP_CLEAR, $urandom, $urandom, $urandom));
    for (int a = 0; a < span; a++) begin
      for (int b = a; b < span; b++) begin
        if ((b == a) ? ($urandom_range(49) == 0)
                     : (a == hub || b == hub || $urandom_range(99) < dens))
          send_item(mk(mlsta_pkg::OP_LOAD, base + a, base + b, $urandom));
        if ($urandom_range(99) == 0) noise_item();
      end
    end
    for (int k = 0; k < (($urandom_range(4) == 0) ? 2 : 1); k++) begin
      send_item(mk(mlsta_pkg::OP_RUN, $urandom, $urandom, $urandom));
      reads = $urandom_range(2, 6);
      for (int i = 0; i < reads; i++)
        send_item(mk(mlsta_pkg::OP_READ, $urandom, $urandom,
                     ($urandom_range(4) == 0) ? $urandom_range(1023)
                                              : $urandom_range(0, edge_cnt + 1)));
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    out_stall_i = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = 400;
        hold_req = 1'b0;
      end
      if (hold_left > 0) hold_left--;
      out_stall_i <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    mlsta_pkg::out_t w;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          w = results_due.pop_front();
          if (out_item_o.kind !== w.kind)
            report_mismatch("kind", out_item_o.kind, w.kind);
          if (out_item_o.tree_edge_count !== w.tree_edge_count)
            report_mismatch("tree_edge_count", out_item_o.tree_edge_count, w.tree_edge_count);
          if (out_item_o.leaf_count !== w.leaf_count)
            report_mismatch("leaf_count", out_item_o.leaf_count, w.leaf_count);
          if (out_item_o.overflow !== w.overflow)
            report_mismatch("overflow", out_item_o.overflow, w.overflow);
          if (out_item_o.parent !== w.parent)
            report_mismatch("parent", out_item_o.parent, w.parent);
          if (out_item_o.child !== w.child)
            report_mismatch("child", out_item_o.child, w.child);
        end
      end
    end
  end

  initial begin
    int node_counts [8];
    int idle_modes [4];
    int stall_modes [4];
    int target;
    mlsta_pkg::out_t blank_read;
    mlsta_pkg::out_t blank_run;
    node_counts = '{1024, 1, 2, 40, 17, 1024, 64, 9};
    idle_modes = '{0, 85, 0, 26};
    stall_modes = '{0, 0, 85, 26};
    errors = 0;
    cycles = 0;
    items_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    node_lim = int'(mlsta_pkg::NODE_COUNT_RESET);
    graph_clear();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    blank_read = '0;
    blank_read.kind = mlsta_pkg::KIND_EDGE;
    blank_run = '0;
    blank_run.kind = mlsta_pkg::KIND_SUMMARY;
    add_row(mk(mlsta_pkg::OP_READ, 0, 0, 0), 1'b1, blank_read);
    add_row(mk(mlsta_pkg::OP_RUN, 1023, 1023, 1023), 1'b1, blank_run);
    add_row(mk(mlsta_pkg::OP_CLEAR, 0, 0, 0));
    add_row(mk(mlsta_pkg::OP_READ, 0, 0, 1022), 1'b1, blank_read);
    add_row(mk(mlsta_pkg::OP_LOAD, 0, 1, 0));
    add_row(mk(mlsta_pkg::OP_LOAD, 0, 2, 0));
    add_row(mk(mlsta_pkg::OP_LOAD, 0, 3, 0));
    add_row(mk(mlsta_pkg::OP_LOAD, 1, 4, 0));
    add_row(mk(mlsta_pkg::OP_LOAD, 4, 4, 0));
    add_row(mk(mlsta_pkg::OP_LOAD, 5, 1023, 0));
    add_row(mk(mlsta_pkg::OP_LOAD, 1022, 1023, 1023));
    add_row(mk(mlsta_pkg::OP_RUN, 0, 0, 0));
    add_row(mk(mlsta_pkg::OP_READ, 0, 0, 0));
    add_row(mk(mlsta_pkg::OP_READ, 0, 0, 1));
    add_row(mk(mlsta_pkg::OP_READ, 0, 0, 2));
    add_row(mk(mlsta_pkg::OP_READ, 0, 0, 1022));
    add_row(mk(mlsta_pkg::OP_READ, 1023, 1023, 1023));
    add_row(mk(mlsta_pkg::OP_RUN, 0, 0, 0));
    add_row(mk(mlsta_pkg::OP_CLEAR, 1023, 1023, 1023));
    add_row(mk(mlsta_pkg::OP_READ, 0, 0, 0), 1'b1, blank_read);

    write_node_count(1024);
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);

    target = items_sent;
    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < 2; s++) begin
        wait_idle();
        idle_pct = idle_modes[p];
        stall_pct = stall_modes[p];
        write_node_count(node_counts[p * 2 + s]);
        if (p == 0 && s == 1) hold_req = 1'b1;
        target += 240;
        while (items_sent < target) begin
          if ($urandom_range(9) == 0) begin
            in_valid_i <= 1'b0;
            @(posedge clk_i);
            while (results_due.size() != 0) @(posedge clk_i);
          end
          if ($urandom_range(9) == 0) noise_item();
          else graph_sequence();
        end
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
